@@ sv/ktb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktb_pkg
// Shared constants, codes and types of the keyed countdown timer bank.
// ----------------------------------------------------------------------------
package ktb_pkg;

  localparam int TIMER_SLOTS = 5;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

  localparam int OP_W      = 2;
  localparam int KEY_W     = 64;
  localparam int SECS_W    = 16;
  localparam int KIND_W    = 3;
  localparam int TICK_W    = 27;
  localparam int MAXA_W    = 3;
  localparam int TPS_W     = 10;
  localparam int PROD_W    = SECS_W + TPS_W;
  localparam int CMP_W     = (CNT_W > MAXA_W) ? CNT_W : MAXA_W;
  localparam int DSTEP_W   = $clog2(TICK_W);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 10;

  // opcodes
  localparam logic [OP_W-1:0] OP_SET  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SET_OK     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NO_SPACE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LIST_ENTRY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST_EMPTY = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_LIMIT      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 8'd1;

  localparam logic [MAXA_W-1:0] TIMER_LIMIT_RST = 3'd1;
  localparam logic [TPS_W-1:0]  TPS_RST         = 10'd100;

  typedef struct packed {
    logic [MAXA_W-1:0] timer_limit;
    logic [TPS_W-1:0]  tps;
  } ktb_cfg_t;

  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] dividend;
    logic [TPS_W-1:0]  divisor;
  } ktb_div_req_t;

  typedef struct packed {
    logic              done;
    logic [SECS_W-1:0] quot;
  } ktb_div_rsp_t;

endpackage

@@ sv/ktb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktb_if
// Handshake channels of the timer bank: command items, result items and
// configuration writes.
// ----------------------------------------------------------------------------
interface ktb_in_if;
  logic                     valid;
  logic                     ready;
  logic [ktb_pkg::OP_W-1:0]   opcode;
  logic [ktb_pkg::KEY_W-1:0]  key;
  logic [ktb_pkg::SECS_W-1:0] seconds;

  modport source (output valid, opcode, key, seconds, input ready);
  modport sink   (input valid, opcode, key, seconds, output ready);
endinterface

interface ktb_out_if;
  logic                       valid;
  logic                       ready;
  logic [ktb_pkg::KIND_W-1:0] kind;
  logic [ktb_pkg::KEY_W-1:0]  out_key;
  logic [ktb_pkg::SECS_W-1:0] remaining_seconds;
  logic                       last;

  modport source (output valid, kind, out_key, remaining_seconds, last, input ready);
  modport sink   (input valid, kind, out_key, remaining_seconds, last, output ready);
endinterface

interface ktb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ktb_pkg::CFG_IDX_W-1:0]  index;
  logic [ktb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/keyed_countdown_timer_bank_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_countdown_timer_bank_top
// Bank of keyed countdown timers with set, tick and sorted list commands.
// ----------------------------------------------------------------------------
// Channels: req takes command items (opcode, key, seconds), rsp gives result
// items (kind, out_key, remaining_seconds, last), cfg writes the timer limit
// (index 0) and ticks_per_second (index 1); cfg is always ready.
// One item at a time; req.ready is high only while the sequencer is idle.
// The sequencer walks the slots one per cycle, holding where a result waits
// for the output register or the divider is busy:
//   set:  a scan of every slot, then the result and a return to idle.
//   tick: one slot per cycle; an expiring slot holds until the output
//         register can take its result.
//   list: the bit-serial divider runs once per active slot, then a
//         selection scan of every slot precedes each entry.
// A finished result waits in the output register while the next item is
// taken; when rsp stalls, the sequencer holds at the next result it must
// send and resumes when the register frees.
// Reset (rst, synchronous) clears all slots to inactive and loads a timer
// limit of 1 and ticks_per_second 100. No clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_countdown_timer_bank_top (
  input  logic      clk,
  input  logic      rst,
  ktb_in_if.sink    req,
  ktb_out_if.source rsp,
  ktb_cfg_if.sink   cfg
);
  import ktb_pkg::*;

  ktb_cfg_t     cfg_q;
  ktb_div_req_t div_req;
  ktb_div_rsp_t div_rsp;

  ktb_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  ktb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ktb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .cfg_q   (cfg_q),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

endmodule

@@ sv/ktb_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktb_cfg_regs
// Configuration register file: limit on active timers and ticks per second.
// ----------------------------------------------------------------------------
module ktb_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  ktb_cfg_if.sink           cfg,
  output ktb_pkg::ktb_cfg_t cfg_q
);
  import ktb_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.timer_limit <= TIMER_LIMIT_RST;
      cfg_q.tps         <= TPS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TIMER_LIMIT:      cfg_q.timer_limit <= cfg.data[MAXA_W-1:0];
        REG_TICKS_PER_SECOND: cfg_q.tps         <= cfg.data[TPS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/ktb_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktb_div
// Restoring divider, one quotient bit per cycle: remaining ticks over ticks
// per second, giving whole seconds saturated to 16 bits (0 for divisor 0).
// ----------------------------------------------------------------------------
module ktb_div (
  input  logic                  clk,
  input  logic                  rst,
  input  ktb_pkg::ktb_div_req_t req,
  output ktb_pkg::ktb_div_rsp_t rsp
);
  import ktb_pkg::*;

  localparam logic [DSTEP_W-1:0] LAST_STEP = DSTEP_W'(TICK_W - 1);

  logic                busy;
  logic                done;
  logic [DSTEP_W-1:0]  step;
  logic [TPS_W:0]      r;
  logic [TICK_W-1:0]   q;
  logic [TPS_W-1:0]    d;
  logic [SECS_W-1:0]   quot;

  logic [TPS_W:0]      r_sh;
  logic                ge;
  logic [TPS_W:0]      r_next;
  logic [TICK_W-1:0]   q_next;

  always_comb begin
    r_sh   = {r[TPS_W-1:0], q[TICK_W-1]};
    ge     = r_sh >= {1'b0, d};
    r_next = ge ? (r_sh - {1'b0, d}) : r_sh;
    q_next = {q[TICK_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        r    <= '0;
        q    <= req.dividend;
        d    <= req.divisor;
      end else if (busy) begin
        r <= r_next;
        q <= q_next;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (d == '0)
            quot <= '0;
          else if (q_next[TICK_W-1:SECS_W] != '0)
            quot <= '1;
          else
            quot <= q_next[SECS_W-1:0];
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

@@ sv/ktb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktb_ctrl
// Slot storage and sequencer: walks the slots one per cycle for set, tick
// and list items while not held by the divider or output register it drives.
// ----------------------------------------------------------------------------
module ktb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  ktb_in_if.sink                req,
  ktb_out_if.source             rsp,
  input  ktb_pkg::ktb_cfg_t     cfg_q,
  output ktb_pkg::ktb_div_req_t div_req,
  input  ktb_pkg::ktb_div_rsp_t div_rsp
);
  import ktb_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SET_SCAN, S_SET_DONE, S_TICK_SCAN,
    S_LIST_DIV, S_LIST_WAIT, S_LIST_FIND, S_LIST_EMIT, S_EMPTY
  } state_t;

  state_t state;

  logic [TIMER_SLOTS-1:0] active;
  logic [KEY_W-1:0]       slot_key   [TIMER_SLOTS];
  logic [TICK_W-1:0]      slot_ticks [TIMER_SLOTS];
  logic [SECS_W-1:0]      slot_secs  [TIMER_SLOTS];

  logic [SLOT_W-1:0]      idx;
  logic [KEY_W-1:0]       key_r;
  logic [TICK_W-1:0]      ticks_r;
  logic [CNT_W-1:0]       cnt;
  logic                   match;
  logic [SLOT_W-1:0]      match_idx;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;
  logic [TIMER_SLOTS-1:0] exp_mask;
  logic [CNT_W-1:0]       emit_cnt;
  logic                   have_prev;
  logic                   have_best;
  logic [SECS_W+KEY_W-1:0] prev;
  logic [SECS_W+KEY_W-1:0] best;
  logic                   div_start;

  logic                   ov;
  logic [KIND_W-1:0]      okind;
  logic [KEY_W-1:0]       okey;
  logic [SECS_W-1:0]      osecs;
  logic                   olast;

  logic [PROD_W-1:0]      prod;
  logic [TIMER_SLOTS-1:0] exp_now;
  logic [TIMER_SLOTS-1:0] exp_rest;
  logic                   later_none;
  logic [CMP_W-1:0]       limit;
  logic [SECS_W+KEY_W-1:0] cand;
  logic                   out_free;

  assign prod     = PROD_W'(req.seconds) * PROD_W'(cfg_q.tps);
  assign out_free = !ov || rsp.ready;
  assign limit    = (CMP_W'(cfg_q.timer_limit) > CMP_W'(TIMER_SLOTS)) ?
                    CMP_W'(TIMER_SLOTS) : CMP_W'(cfg_q.timer_limit);
  assign cand     = {slot_secs[idx], slot_key[idx]};

  always_comb begin
    for (int i = 0; i < TIMER_SLOTS; i++)
      exp_now[i] = active[i] && (slot_ticks[i] <= TICK_W'(1));
    exp_rest   = exp_mask >> idx;
    later_none = (exp_rest >> 1) == '0;
  end

  assign req.ready = (state == S_IDLE);

  assign div_req.start    = div_start;
  assign div_req.dividend = slot_ticks[idx];
  assign div_req.divisor  = cfg_q.tps;

  assign rsp.valid             = ov;
  assign rsp.kind              = okind;
  assign rsp.out_key           = okey;
  assign rsp.remaining_seconds = osecs;
  assign rsp.last              = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      ov        <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (rsp.ready)
        ov <= 1'b0;

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            key_r      <= req.key;
            ticks_r    <= TICK_W'(prod);
            idx        <= '0;
            cnt        <= '0;
            match      <= 1'b0;
            free_found <= 1'b0;
            exp_mask   <= exp_now;
            case (req.opcode)
              OP_SET:  state <= S_SET_SCAN;
              OP_TICK: state <= S_TICK_SCAN;
              OP_LIST: state <= S_LIST_DIV;
              default: state <= S_IDLE;
            endcase
          end
        end

        S_SET_SCAN: begin
          if (active[idx]) begin
            cnt <= cnt + 1'b1;
            if (!match && slot_key[idx] == key_r) begin
              match     <= 1'b1;
              match_idx <= idx;
            end
          end else if (!free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (idx == LAST_SLOT)
            state <= S_SET_DONE;
          else
            idx <= idx + 1'b1;
        end

        S_SET_DONE: begin
          if (out_free) begin
            ov    <= 1'b1;
            okey  <= key_r;
            osecs <= '0;
            olast <= 1'b1;
            okind <= KIND_SET_OK;
            if (match) begin
              slot_ticks[match_idx] <= ticks_r;
            end else if (CMP_W'(cnt) < limit && free_found) begin
              active[free_idx]     <= 1'b1;
              slot_key[free_idx]   <= key_r;
              slot_ticks[free_idx] <= ticks_r;
            end else begin
              okind <= KIND_NO_SPACE;
            end
            state <= S_IDLE;
          end
        end

        S_TICK_SCAN: begin
          if (exp_mask[idx]) begin
            // hold until the output register can take the expiry
            if (out_free) begin
              active[idx]     <= 1'b0;
              slot_ticks[idx] <= '0;
              ov    <= 1'b1;
              okind <= KIND_EXPIRED;
              okey  <= slot_key[idx];
              osecs <= '0;
              olast <= later_none;
              if (idx == LAST_SLOT)
                state <= S_IDLE;
              else
                idx <= idx + 1'b1;
            end
          end else begin
            if (active[idx])
              slot_ticks[idx] <= slot_ticks[idx] - 1'b1;
            if (idx == LAST_SLOT)
              state <= S_IDLE;
            else
              idx <= idx + 1'b1;
          end
        end

        S_LIST_DIV: begin
          if (active[idx]) begin
            div_start <= 1'b1;
            cnt       <= cnt + 1'b1;
            state     <= S_LIST_WAIT;
          end else if (idx == LAST_SLOT) begin
            idx       <= '0;
            emit_cnt  <= '0;
            have_prev <= 1'b0;
            have_best <= 1'b0;
            state     <= (cnt == '0) ? S_EMPTY : S_LIST_FIND;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_LIST_WAIT: begin
          if (div_rsp.done) begin
            slot_secs[idx] <= div_rsp.quot;
            if (idx == LAST_SLOT) begin
              idx       <= '0;
              emit_cnt  <= '0;
              have_prev <= 1'b0;
              have_best <= 1'b0;
              state     <= S_LIST_FIND;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_LIST_DIV;
            end
          end
        end

        // keys of active slots are unique, so the next entry is the
        // smallest (seconds, key) above the one just sent
        S_LIST_FIND: begin
          if (active[idx] && (!have_prev || cand > prev) &&
              (!have_best || cand < best)) begin
            best      <= cand;
            have_best <= 1'b1;
          end
          if (idx == LAST_SLOT)
            state <= S_LIST_EMIT;
          else
            idx <= idx + 1'b1;
        end

        S_LIST_EMIT: begin
          if (out_free) begin
            ov        <= 1'b1;
            okind     <= KIND_LIST_ENTRY;
            okey      <= best[KEY_W-1:0];
            osecs     <= best[SECS_W+KEY_W-1:KEY_W];
            olast     <= (emit_cnt == cnt - 1'b1);
            prev      <= best;
            have_prev <= 1'b1;
            have_best <= 1'b0;
            idx       <= '0;
            emit_cnt  <= emit_cnt + 1'b1;
            state     <= (emit_cnt == cnt - 1'b1) ? S_IDLE : S_LIST_FIND;
          end
        end

        S_EMPTY: begin
          if (out_free) begin
            ov    <= 1'b1;
            okind <= KIND_LIST_EMPTY;
            okey  <= '0;
            osecs <= '0;
            olast <= 1'b1;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/ktb_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktb_chk
// Port-level checks on the result channel of the timer bank.
// ----------------------------------------------------------------------------
module ktb_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [ktb_pkg::KIND_W-1:0] kind,
  input logic [ktb_pkg::KEY_W-1:0]  out_key,
  input logic [ktb_pkg::SECS_W-1:0] remaining_seconds,
  input logic                       last
);
  import ktb_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(out_key) &&
      $stable(remaining_seconds) && $stable(last))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> kind <= KIND_LIST_EMPTY)
    else $error("result kind out of range");

  a_secs_list_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind != KIND_LIST_ENTRY |-> remaining_seconds == '0)
    else $error("seconds on a non-list result");

  a_set_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (kind == KIND_SET_OK || kind == KIND_NO_SPACE ||
      kind == KIND_LIST_EMPTY) |-> last)
    else $error("single result without last");

  a_empty_key: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind == KIND_LIST_EMPTY |-> out_key == '0)
    else $error("empty list result with a key");

endmodule

bind keyed_countdown_timer_bank_top ktb_chk u_ktb_chk (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .kind              (rsp.kind),
  .out_key           (rsp.out_key),
  .remaining_seconds (rsp.remaining_seconds),
  .last              (rsp.last)
);

@@ dv/keyed_countdown_timer_bank_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_countdown_timer_bank_top_test
// Self-checking bench for the keyed countdown timer bank. A scoreboard class
// tracks slot state and configuration, predicts the results of every
// accepted command and checks each result item in order. A directed opening
// covers set, refusal, reload, expiry, sorted listing, saturation and zero
// rates. Random phases under several configurations and idle patterns
// follow.
// ----------------------------------------------------------------------------
module keyed_countdown_timer_bank_top_test;
  import ktb_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // give the bank room to go quiet after a full list
  localparam int DRAIN_CYCLES   = 250;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 34;
  localparam int PHASE_MAXA [PHASES] = '{7, 3, 5, 0, 6, 2};
  localparam int PHASE_TPS  [PHASES] = '{2, 1, 1000, 3, 0, 4};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [SECS_W-1:0] secs;
    logic              last;
  } timer_result_t;

  class timer_bank_scoreboard;
    bit                active   [TIMER_SLOTS];
    logic [KEY_W-1:0]  key_of   [TIMER_SLOTS];
    logic [TICK_W-1:0] ticks_of [TIMER_SLOTS];
    logic [MAXA_W-1:0] timer_limit;
    logic [TPS_W-1:0]  tps;
    timer_result_t     expected_q[$];
    int errors, checked, cmds, expiries, entries, refusals;

    function new();
      foreach (active[i]) begin
        active[i]   = 1'b0;
        key_of[i]   = '0;
        ticks_of[i] = '0;
      end
      timer_limit = TIMER_LIMIT_RST;
      tps         = TPS_RST;
      errors      = 0;
      checked     = 0;
      cmds        = 0;
      expiries    = 0;
      entries     = 0;
      refusals    = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_TIMER_LIMIT) timer_limit = val[MAXA_W-1:0];
      else if (idx == REG_TICKS_PER_SECOND) tps = val[TPS_W-1:0];
    endfunction

    function logic [SECS_W-1:0] whole_seconds(logic [TICK_W-1:0] t);
      int unsigned s;
      if (tps == '0) return '0;
      s = 32'(t) / 32'(tps);
      return (s > 65535) ? 16'hFFFF : s[SECS_W-1:0];
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] k,
                       logic [SECS_W-1:0] s, logic last);
      timer_result_t r;
      r.kind = kind;
      r.key  = k;
      r.secs = s;
      r.last = last;
      expected_q.push_back(r);
    endfunction

    function void note_cmd(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                           logic [SECS_W-1:0] s);
      logic [TICK_W-1:0] load;
      logic [KEY_W-1:0]  lkey [TIMER_SLOTS];
      logic [SECS_W-1:0] lsec [TIMER_SLOTS];
      logic [KEY_W-1:0]  tk;
      logic [SECS_W-1:0] ts;
      int unsigned       limit, busy;
      int                hit, free_slot, n, j;
      cmds++;
      n = 0;
      case (op)
        OP_SET: begin
          load      = TICK_W'(32'(s) * 32'(tps));
          limit     = (timer_limit > TIMER_SLOTS) ? TIMER_SLOTS : timer_limit;
          hit       = -1;
          free_slot = -1;
          busy      = 0;
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (active[i] && key_of[i] == k && hit < 0) hit = i;
            if (active[i]) busy++;
            else if (free_slot < 0) free_slot = i;
          end
          // a matching key reloads even when the bank is at its limit
          if (hit >= 0) begin
            ticks_of[hit] = load;
          end else if (busy < limit) begin
            hit              = free_slot;
            active[hit]      = 1'b1;
            key_of[hit]      = k;
            ticks_of[hit]    = load;
          end
          if (hit < 0) refusals++;
          push((hit >= 0) ? KIND_SET_OK : KIND_NO_SPACE, k, '0, 1'b1);
        end
        OP_TICK: begin
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (active[i]) begin
              if (ticks_of[i] <= 1) begin
                ticks_of[i] = '0;
                active[i]   = 1'b0;
                push(KIND_EXPIRED, key_of[i], '0, 1'b0);
                n++;
              end else begin
                ticks_of[i] = ticks_of[i] - 1'b1;
              end
            end
          end
          expiries += n;
          if (n > 0) expected_q[expected_q.size()-1].last = 1'b1;
        end
        OP_LIST: begin
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (active[i]) begin
              lkey[n] = key_of[i];
              lsec[n] = whole_seconds(ticks_of[i]);
              n++;
            end
          end
          // order by whole seconds, then by key
          for (int i = 1; i < n; i++) begin
            tk = lkey[i];
            ts = lsec[i];
            j  = i - 1;
            while (j >= 0 && (lsec[j] > ts || (lsec[j] == ts && lkey[j] > tk))) begin
              lkey[j+1] = lkey[j];
              lsec[j+1] = lsec[j];
              j--;
            end
            lkey[j+1] = tk;
            lsec[j+1] = ts;
          end
          if (n == 0) push(KIND_LIST_EMPTY, '0, '0, 1'b1);
          for (int i = 0; i < n; i++) push(KIND_LIST_ENTRY, lkey[i], lsec[i], i == n - 1);
          entries += n;
        end
        default: ;
      endcase
    endfunction

    function int field_mismatch(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
      if (want === got) return 0;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      return 1;
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] k,
                               logic [SECS_W-1:0] s, logic last);
      timer_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d key %h secs %0d last %0b",
                 $time, kind, k, s, last);
        return;
      end
      want = expected_q.pop_front();
      errors += field_mismatch("kind", KEY_W'(want.kind), KEY_W'(kind));
      errors += field_mismatch("out_key", want.key, k);
      errors += field_mismatch("remaining_seconds", KEY_W'(want.secs), KEY_W'(s));
      errors += field_mismatch("last", KEY_W'(want.last), KEY_W'(last));
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_cycles;

  timer_bank_scoreboard sb = new();

  ktb_in_if  cmd_ch();
  ktb_out_if res_ch();
  ktb_cfg_if cfg_ch();

  keyed_countdown_timer_bank_top uut (
    .clk (clk),
    .rst (rst),
    .req (cmd_ch),
    .rsp (res_ch),
    .cfg (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.kind, res_ch.out_key, res_ch.remaining_seconds, res_ch.last);
  end

  // end the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, stall_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                          input logic [SECS_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.opcode  <= op;
    cmd_ch.key     <= k;
    cmd_ch.seconds <= s;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_cmd(op, k, s);
  endtask

  // hold off until every result is out and the sequencer has gone quiet
  task automatic drain_bank();
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    sb.note_cfg(idx, CFG_DATA_W'(val));
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // zero every live timer, then let one tick expire them all
  task automatic clear_timers();
    for (int i = 0; i < TIMER_SLOTS; i++)
      if (sb.active[i]) send_cmd(OP_SET, sb.key_of[i], '0);
    send_cmd(OP_TICK, '0, '0);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    int start;
    r     = $urandom_range(99);
    start = $urandom_range(TIMER_SLOTS - 1);
    if (r < 40) begin
      for (int i = 0; i < TIMER_SLOTS; i++)
        if (sb.active[(start + i) % TIMER_SLOTS]) return sb.key_of[(start + i) % TIMER_SLOTS];
    end
    // a small pool of keys makes key ties and reloads common
    if (r < 75) return KEY_W'($urandom_range(7));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SECS_W-1:0] pick_secs();
    int r;
    r = $urandom_range(99);
    if (r < 70) return SECS_W'($urandom_range(3));
    if (r < 90) return SECS_W'($urandom_range(20));
    if (r < 97) return SECS_W'($urandom_range(65535));
    return 16'hFFFF;
  endfunction

  initial begin
    logic [OP_W-1:0] op;
    int              r;
    int              n;
    rst            = 1'b1;
    send_idle_pct  = 21;
    recv_idle_pct  = 65;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.opcode  <= OP_SET;
    cmd_ch.key     <= '0;
    cmd_ch.seconds <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_TIMER_LIMIT;
    cfg_ch.data    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: one timer at most, 100 ticks per second
    send_cmd(OP_LIST, '0, '0);
    send_cmd(OP_UNUSED, {$urandom, $urandom}, SECS_W'($urandom));
    send_cmd(OP_TICK, '0, '0);
    send_cmd(OP_SET, '1, 16'hFFFF);
    send_cmd(OP_SET, '0, '0);
    send_cmd(OP_SET, '1, '0);
    send_cmd(OP_TICK, '0, '0);

    drain_bank();
    write_reg(REG_TIMER_LIMIT, 7);
    write_reg(REG_TICKS_PER_SECOND, 1000);
    send_cmd(OP_SET, '0, 16'hFFFF);
    send_cmd(OP_SET, '1, 16'd7);
    send_cmd(OP_SET, 64'h8000_0000_0000_0001, 16'd7);
    send_cmd(OP_SET, 64'h5A5A_A5A5_5A5A_A5A5, 16'd1);
    send_cmd(OP_SET, 64'h1234, '0);
    send_cmd(OP_SET, 64'hDEAD, 16'd3);
    send_cmd(OP_LIST, '0, '0);
    send_cmd(OP_TICK, '0, '0);
    send_cmd(OP_LIST, '0, '0);

    // one tick per second pushes the long timer past the seconds range
    drain_bank();
    write_reg(REG_TICKS_PER_SECOND, 1);
    send_cmd(OP_LIST, '0, '0);

    drain_bank();
    write_reg(REG_TICKS_PER_SECOND, 0);
    write_reg(REG_TIMER_LIMIT, 0);
    send_cmd(OP_LIST, '0, '0);
    send_cmd(OP_SET, 64'hDEAD, 16'd9);
    send_cmd(OP_SET, 64'h5A5A_A5A5_5A5A_A5A5, 16'd9);
    send_cmd(OP_TICK, '0, '0);
    clear_timers();

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 65 : 0;
      recv_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 21 : 0;
      drain_bank();
      write_reg(REG_TIMER_LIMIT, PHASE_MAXA[ph]);
      write_reg(REG_TICKS_PER_SECOND, PHASE_TPS[ph]);
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(99);
        op = (r < 38) ? OP_SET : (r < 78) ? OP_TICK : (r < 94) ? OP_LIST : OP_UNUSED;
        send_cmd(op, pick_key(), pick_secs());
        if (op != OP_UNUSED) n++;
        if ($urandom_range(99) < 3) drain_bank();
      end
      clear_timers();
    end

    drain_bank();
    $display("Ran %0d commands through %0d configuration phases and three idle patterns.",
             sb.cmds, PHASES + 4);
    $display("Checked %0d results: %0d expiries, %0d list entries, %0d refused sets.",
             sb.checked, sb.expiries, sb.entries, sb.refusals);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
